// ===== design/mls_pkg.sv =====
// Shared widths for the modular linear solver.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package mls_pkg;

   localparam int FW = 31;           // field width of coeff, rhs, modulus, solution
   localparam int SW = FW + 2;       // signed width of the Bezout coefficients
   localparam int PW = 2 * FW;       // width of the full product and the dividend shifter
   localparam int CW = $clog2(PW);   // width of the step counter

   localparam logic [FW-1:0] MODULUS_RESET = FW'(10001);

endpackage

// ===== design/mls_if.sv =====
// Channel interfaces for the modular linear solver: request, response, register write.
// Depends on mls_pkg for the field widths.
`timescale 1ns / 1ps

interface mls_req_if;
   logic                  valid;
   logic                  ready;
   logic [mls_pkg::FW-1:0] coeff;
   logic [mls_pkg::FW-1:0] rhs;

   modport source (output valid, output coeff, output rhs, input ready);
   modport sink   (input valid, input coeff, input rhs, output ready);
endinterface

interface mls_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  solvable;
   logic [mls_pkg::FW-1:0] solution;

   modport source (output valid, output solvable, output solution, input ready);
   modport sink   (input valid, input solvable, input solution, output ready);
endinterface

interface mls_csr_if;
   logic                  valid;
   logic                  ready;
   logic [mls_pkg::FW-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/modular_linear_solver.sv =====
// Modular linear solver: solves coeff * s = rhs (mod modulus).
// Depends on mls_pkg and the channel interfaces in mls_if.sv.
//
// Use:
//   csr_ch  writes the modulus; always ready, take effect for the next request.
//   req_ch  takes one request (coeff, rhs) when the block is idle; ready is low
//           from acceptance until the response has been taken.
//   rsp_ch  returns solvable and solution, held stable until rsp_ch.ready.
// Operation:
//   Each Euclid step runs one restoring division through the shared divider,
//   one quotient bit per cycle, between the bookkeeping states CHK and POST,
//   with the quotient times coefficient product accumulated in the same loop.
//   The last pass of that loop divides rhs by the gcd; then quotient mod
//   modulus and a 62 bit product mod modulus follow, each through the same
//   divider and POST. A new request is taken only after the response
//   to the last one has been taken; a zero modulus answers on the cycle
//   after acceptance. One request is in work at a time.
// Reset: synchronous, active high; the modulus returns to 10001 and the block
//   comes up idle and ready. A stalled response simply holds the block.
`timescale 1ns / 1ps

module modular_linear_solver (
   input  logic       clock,
   input  logic       reset,
   mls_req_if.sink    req_ch,
   mls_rsp_if.source  rsp_ch,
   mls_csr_if.sink    csr_ch
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHK  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_POST = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [1:0] OP_EUC  = 2'd0;
   localparam logic [1:0] OP_BDIV = 2'd1;
   localparam logic [1:0] OP_QMOD = 2'd2;
   localparam logic [1:0] OP_PMOD = 2'd3;

   localparam int FW = mls_pkg::FW;
   localparam int SW = mls_pkg::SW;
   localparam int PW = mls_pkg::PW;
   localparam int CW = mls_pkg::CW;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [FW-1:0]        modulus_ff, modulus_in;
   logic [FW-1:0]        n_ff, n_in;
   logic [FW-1:0]        b_ff, b_in;
   logic [FW-1:0]        r0_ff, r0_in;
   logic [FW-1:0]        r1_ff, r1_in;
   logic signed [SW-1:0] s0_ff, s0_in;
   logic signed [SW-1:0] s1_ff, s1_in;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic [PW-1:0]        dq_ff, dq_in;
   logic [FW-1:0]        rem_ff, rem_in;
   logic [FW-1:0]        div_ff, div_in;
   logic [FW-1:0]        mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic                 ok_ff, ok_in;
   logic [FW-1:0]        sol_ff, sol_in;

   logic [FW:0]          shifted;
   logic [FW+1:0]        diff;
   logic                 qbit;
   logic [SW-1:0]        absx;
   logic [SW-1:0]        absx_red;

   assign csr_ch.ready    = 1'b1;
   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = (state_ff == ST_OUT);
   assign rsp_ch.solvable = ok_ff;
   assign rsp_ch.solution = sol_ff;

   // shared divider step, with the quotient times s1 product in the same loop
   always_comb begin
      shifted = {rem_ff, dq_ff[PW-1]};
      diff    = {1'b0, shifted} - {2'b00, div_ff};
      qbit    = ~diff[FW+1];
      absx    = s0_ff[SW-1] ? SW'(-s0_ff) : SW'(s0_ff);
      absx_red = (absx >= {2'b00, n_ff}) ? (absx - {2'b00, n_ff}) : absx;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      modulus_in = modulus_ff;
      n_in       = n_ff;
      b_in       = b_ff;
      r0_in      = r0_ff;
      r1_in      = r1_ff;
      s0_in      = s0_ff;
      s1_in      = s1_ff;
      acc_in     = acc_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      ok_in      = ok_ff;
      sol_in     = sol_ff;

      if (csr_ch.valid) begin
         modulus_in = csr_ch.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               n_in  = modulus_ff;
               b_in  = req_ch.rhs;
               r0_in = req_ch.coeff;
               r1_in = modulus_ff;
               s0_in = SW'(1);
               s1_in = '0;
               if (modulus_ff == '0) begin
                  ok_in    = 1'b0;
                  sol_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_CHK;
               end
            end
         end
         ST_CHK: begin
            rem_in   = '0;
            acc_in   = '0;
            count_in = CW'(FW - 1);
            state_in = ST_DIV;
            if (r1_ff == '0) begin
               op_in  = OP_BDIV;
               dq_in  = {b_ff, FW'(0)};
               div_in = r0_ff;
            end else begin
               op_in  = OP_EUC;
               dq_in  = {r0_ff, FW'(0)};
               div_in = r1_ff;
            end
         end
         ST_DIV: begin
            dq_in  = {dq_ff[PW-2:0], qbit};
            rem_in = qbit ? diff[FW-1:0] : shifted[FW-1:0];
            acc_in = (acc_ff <<< 1) + (qbit ? s1_ff : SW'(0));
            count_in = count_ff - CW'(1);
            if (count_ff == '0) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            unique case (op_ff)
               OP_EUC: begin
                  r0_in    = r1_ff;
                  r1_in    = rem_ff;
                  s0_in    = s1_ff;
                  s1_in    = s0_ff - acc_ff;
                  state_in = ST_CHK;
               end
               OP_BDIV: begin
                  if (rem_ff != '0) begin
                     ok_in    = 1'b0;
                     sol_in   = '0;
                     state_in = ST_OUT;
                  end else begin
                     neg_in   = s0_ff[SW-1];
                     mag_in   = absx_red[FW-1:0];
                     op_in    = OP_QMOD;
                     dq_in    = {dq_ff[FW-1:0], FW'(0)};
                     div_in   = n_ff;
                     rem_in   = '0;
                     acc_in   = '0;
                     count_in = CW'(FW - 1);
                     state_in = ST_DIV;
                  end
               end
               OP_QMOD: begin
                  op_in    = OP_PMOD;
                  dq_in    = PW'(mag_ff) * PW'(rem_ff);
                  div_in   = n_ff;
                  rem_in   = '0;
                  acc_in   = '0;
                  count_in = CW'(PW - 1);
                  state_in = ST_DIV;
               end
               OP_PMOD: begin
                  ok_in    = 1'b1;
                  sol_in   = (neg_ff && rem_ff != '0) ? (n_ff - rem_ff) : rem_ff;
                  state_in = ST_OUT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         modulus_ff <= mls_pkg::MODULUS_RESET;
      end else begin
         state_ff   <= state_in;
         modulus_ff <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      count_ff <= count_in;
      n_ff     <= n_in;
      b_ff     <= b_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      s0_ff    <= s0_in;
      s1_ff    <= s1_in;
      acc_ff   <= acc_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      ok_ff    <= ok_in;
      sol_ff   <= sol_in;
   end

endmodule

// ===== design/mls_checker.sv =====
// Port-level checks for the modular linear solver, bound to the top level.
// Depends on mls_pkg for the field width.
`timescale 1ns / 1ps

module mls_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_solvable,
   input logic [mls_pkg::FW-1:0] rsp_solution
);

   // one request in work: busy right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one is in work");

   // no new request while a response waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready for a request while a response is pending");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_solvable) && $stable(rsp_solution)))
      else $error("stalled response changed or dropped");

   // no solution reads as zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_solvable) |-> (rsp_solution == '0))
      else $error("unsolvable response with a non-zero solution");

endmodule

bind modular_linear_solver mls_checker u_mls_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_solvable (rsp_ch.solvable),
   .rsp_solution (rsp_ch.solution)
);

// ===== tb/modular_linear_solver_tb.sv =====
// Self-checking testbench for modular_linear_solver: directed table, then random phases.
// Depends on mls_pkg, the channel interfaces in mls_if.sv and the solver top level.
`timescale 1ns / 1ps

module modular_linear_solver_tb;

   localparam int                 FW           = mls_pkg::FW;
   localparam int                 IDLE_PERCENT = 37;
   localparam int                 PHASES       = 7;
   localparam int                 PHASE_ITEMS  = 43;
   localparam int                 HOLD_AT      = 90;
   localparam int                 HOLD_CYCLES  = 3000;
   localparam int                 SETTLE       = 8;
   localparam logic [FW-1:0]      TOP          = {FW{1'b1}};
   localparam logic [FW-1:0]      FIB45        = FW'(1134903170);
   localparam logic [FW-1:0]      FIB46        = FW'(1836311903);

   typedef struct packed {
      logic          solvable;
      logic [FW-1:0] solution;
   } answer_type;

   typedef struct packed {
      logic [FW-1:0] modulus;
      logic [FW-1:0] coeff;
      logic [FW-1:0] rhs;
      logic          known;
      logic          solvable;
      logic [FW-1:0] solution;
   } vector_type;

   localparam int NUM_VECTORS = 25;
   localparam vector_type DIRECTED [NUM_VECTORS] = '{
      '{FW'(10001), FW'(0),     FW'(0),     1'b1, 1'b1, FW'(0)},
      '{FW'(10001), FW'(0),     FW'(1),     1'b1, 1'b0, FW'(0)},
      '{FW'(10001), FW'(1),     FW'(5),     1'b1, 1'b1, FW'(5)},
      '{FW'(10001), FW'(73),    FW'(1),     1'b1, 1'b0, FW'(0)},
      '{FW'(10001), FW'(73),    FW'(146),   1'b0, 1'b0, FW'(0)},
      '{FW'(10001), FW'(10001), FW'(10001), 1'b1, 1'b1, FW'(0)},
      '{FW'(10001), FW'(20002), FW'(7),     1'b1, 1'b0, FW'(0)},
      '{FW'(10001), TOP,        TOP,        1'b0, 1'b0, FW'(0)},
      '{FW'(10001), FW'(9999),  FW'(1),     1'b0, 1'b0, FW'(0)},
      '{FW'(0),     FW'(5),     FW'(5),     1'b1, 1'b0, FW'(0)},
      '{FW'(0),     FW'(0),     FW'(0),     1'b1, 1'b0, FW'(0)},
      '{FW'(0),     TOP,        TOP,        1'b1, 1'b0, FW'(0)},
      '{FW'(1),     FW'(0),     FW'(0),     1'b1, 1'b1, FW'(0)},
      '{FW'(1),     TOP,        TOP,        1'b1, 1'b1, FW'(0)},
      '{FW'(1),     FW'(12345), FW'(1),     1'b1, 1'b1, FW'(0)},
      '{TOP,        FW'(1),     TOP,        1'b1, 1'b1, FW'(0)},
      '{TOP,        FW'(1),     FW'(1),     1'b1, 1'b1, FW'(1)},
      '{TOP,        TOP,        FW'(0),     1'b1, 1'b1, FW'(0)},
      '{TOP,        TOP,        FW'(1),     1'b1, 1'b0, FW'(0)},
      '{TOP,        FW'(2),     FW'(1),     1'b0, 1'b0, FW'(0)},
      '{TOP,        TOP - 1'b1, TOP,        1'b0, 1'b0, FW'(0)},
      '{FW'(2),     FW'(1),     FW'(1),     1'b0, 1'b0, FW'(0)},
      '{FW'(2),     FW'(2),     FW'(1),     1'b1, 1'b0, FW'(0)},
      '{FIB46,      FIB45,      FW'(1),     1'b0, 1'b0, FW'(0)},
      '{FIB46,      FIB45,      TOP,        1'b0, 1'b0, FW'(0)}
   };

   logic clock = 1'b0;
   logic reset;

   mls_req_if req_ch ();
   mls_rsp_if rsp_ch ();
   mls_csr_if csr_ch ();

   modular_linear_solver uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   answer_type    answers_due [$];
   answer_type    oldest;
   logic [FW-1:0] modulus_now = FW'(10001);
   int            mismatches = 0;
   int            answers_seen = 0;
   bit            steady = 1'b0;

   always #2 clock = ~clock;

   function automatic answer_type solve_congruence(logic [FW-1:0] a, logic [FW-1:0] b,
                                                   logic [FW-1:0] n);
      longint          r0, r1, s0, s1, q, t;
      longint unsigned g, mag, quot, prod;
      answer_type      res;
      res = '0;
      if (n == '0) return res;
      r0 = longint'(a);
      r1 = longint'(n);
      s0 = 1;
      s1 = 0;
      while (r1 != 0) begin
         q  = r0 / r1;
         t  = r0 - q * r1;
         r0 = r1;
         r1 = t;
         t  = s0 - q * s1;
         s0 = s1;
         s1 = t;
      end
      g = longint'(r0);
      if (64'(b) % g != 0) return res;
      quot = 64'(b) / g;
      mag  = (s0 < 0) ? longint'(-s0) : longint'(s0);
      prod = ((mag % 64'(n)) * (quot % 64'(n))) % 64'(n);
      if (s0 < 0 && prod != 0) prod = 64'(n) - prod;
      res.solvable = 1'b1;
      res.solution = prod[FW-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic offer_request(logic [FW-1:0] a, logic [FW-1:0] b, bit known,
                                answer_type want);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.coeff <= a;
      req_ch.rhs   <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      answers_due.push_back(known ? want : solve_congruence(a, b, modulus_now));
   endtask

   task automatic drain_answers();
      req_ch.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_modulus(logic [FW-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      modulus_now = value;
   endtask

   // stimulus
   initial begin
      logic [31:0]   rnd;
      logic [FW-1:0] a, b, n;
      int unsigned   g;
      answer_type    want;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.coeff <= '0;
      req_ch.rhs   <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_VECTORS; i++) begin
         if (DIRECTED[i].modulus != modulus_now) begin
            drain_answers();
            write_modulus(DIRECTED[i].modulus);
         end
         want.solvable = DIRECTED[i].solvable;
         want.solution = DIRECTED[i].solution;
         offer_request(DIRECTED[i].coeff, DIRECTED[i].rhs, DIRECTED[i].known, want);
      end

      for (int p = 0; p < PHASES; p++) begin
         rnd = $urandom();
         case (p)
            0:       n = rnd[FW-1:0];
            1:       n = FW'(720720);
            2:       n = FW'(1) << (FW - 1);
            3:       n = FW'($urandom_range(2, 1000));
            4:       n = FW'($urandom_range(1, 65535));
            5:       n = rnd[FW-1:0] | (FW'(1) << (FW - 1));
            default: n = FW'(30030);
         endcase
         drain_answers();
         write_modulus(n);
         steady = (p == 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(3))
               0, 1: begin
                  rnd = $urandom();
                  a   = rnd[FW-1:0];
                  rnd = $urandom();
                  b   = rnd[FW-1:0];
               end
               2: begin
                  a = FW'($urandom % ({1'b0, modulus_now} + 32'd1));
                  b = FW'($urandom % ({1'b0, modulus_now} + 32'd1));
               end
               default: begin
                  g = $urandom_range(1, 64);
                  a = FW'(g * $urandom_range(0, 1000));
                  b = FW'(g * $urandom_range(0, 30000000));
               end
            endcase
            offer_request(a, b, 1'b0, '0);
         end
         steady = 1'b0;
      end

      drain_answers();
      repeat (64) @(posedge clock);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("modular_linear_solver_tb passed");
      end else begin
         $display("modular_linear_solver_tb failed");
      end
      $finish;
   end

   // response side: random back-pressure, one long hold
   initial begin
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && answers_seen >= HOLD_AT) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
         end
         if (steady) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         answers_seen++;
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("response with nothing outstanding: solvable %0d solution %0d",
                                      rsp_ch.solvable, rsp_ch.solution));
         end else begin
            oldest = answers_due.pop_front();
            if (rsp_ch.solvable !== oldest.solvable)
               report_mismatch($sformatf("solvable expected %0d, got %0d",
                                         oldest.solvable, rsp_ch.solvable));
            if (rsp_ch.solution !== oldest.solution)
               report_mismatch($sformatf("solution expected %0d, got %0d",
                                         oldest.solution, rsp_ch.solution));
         end
      end
   end

   initial begin
      #12_000_000;
      $display("modular_linear_solver_tb failed");
      $finish;
   end

endmodule
